// ===== rtl/core/swes_pkg.sv =====
// Package: shared constants, types and helpers for the single-wire EEPROM slave.
`timescale 1ns / 1ps
`default_nettype none

package swes_pkg;

   localparam int MEM_BYTES = 128;
   localparam int ID_BYTES  = 3;
   localparam int MEM_AW    = $clog2(MEM_BYTES);

   localparam int DUR_W  = 16;
   localparam int FUNC_W = 3;
   localparam int LA_W   = 7;
   localparam int BYTE_W = 8;
   localparam int PTR_W  = 8;
   localparam int BP_W   = 4;
   localparam int ST_W   = 3;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 24;
   localparam int DEV_W  = 3;
   localparam int ID_W   = 24;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_ROSE    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FELL    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ENRESET = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PRELOAD = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IW-1:0] CSR_RESET_LOW  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_ONE_BIT    = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_DISC_HIGH  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DEV_SELECT = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_MFG_ID     = 3'd4;

   localparam logic [DUR_W-1:0] RESET_LOW_DEFAULT = 16'd100;
   localparam logic [DUR_W-1:0] ONE_BIT_DEFAULT   = 16'd5;
   localparam logic [DUR_W-1:0] DISC_HIGH_DEFAULT = 16'd10;

   // command byte opcodes (upper nibble)
   localparam logic [3:0] OPC_MEMORY = 4'hA;
   localparam logic [3:0] OPC_IDENT  = 4'hC;

   typedef struct packed {
      logic [PTR_W-1:0] ptr;
      logic [BP_W-1:0]  bp;
      logic             zero;
      logic             ack;
   } adv_type;

   // pointer rolled back to zero once it is past the region
   function automatic logic [PTR_W-1:0] wrap_ptr(input logic is_id, input logic [PTR_W-1:0] p);
      logic [PTR_W:0] size;
      size = is_id ? (PTR_W+1)'(ID_BYTES) : (PTR_W+1)'(MEM_BYTES);
      return ({1'b0, p} >= size) ? '0 : p;
   endfunction

   // one transmit slot: pick the bit, flag a low drive or an expected host ack
   function automatic adv_type advance(input logic is_id, input logic [PTR_W-1:0] p,
                                       input logic [BP_W-1:0] bp, input logic [BYTE_W-1:0] mb,
                                       input logic [ID_W-1:0] id);
      adv_type          r;
      logic [BYTE_W-1:0] b;
      r.ptr  = wrap_ptr(is_id, p);
      r.zero = 1'b0;
      r.ack  = 1'b0;
      if (is_id) begin
         case (r.ptr[1:0])
            2'd0:    b = id[23:16];
            2'd1:    b = id[15:8];
            default: b = id[7:0];
         endcase
      end else begin
         b = mb;
      end
      if (!bp[3]) begin
         r.zero = !b[~bp[2:0]];
      end else if (bp == 4'd9) begin
         r.ack = 1'b1;
      end
      r.bp = bp + 4'd1;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/swes_ram.sv =====
// Generic RAM: one write port, two registered read ports, write-first on collision.
`timescale 1ns / 1ps
`default_nettype none

module swes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire  [$clog2(DEPTH)-1:0] waddr,
   input  wire  [WIDTH-1:0]         wdata,
   input  wire  [$clog2(DEPTH)-1:0] raddr_a,
   input  wire  [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= (we && waddr == raddr_a) ? wdata : mem_ff[raddr_a];
      rdata_b_ff <= (we && waddr == raddr_b) ? wdata : mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ===== rtl/core/single_wire_eeprom_slave_core.sv =====
// Top level: single-wire EEPROM bus slave, read side, one line event per cycle while req_ready is high.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   func, duration, load_address, load_data
//   rsp      out        rsp_valid/rsp_ready   drive_low, bus_state, address_pointer
//   csr      in         csr_write             csr_index, csr_wdata
//
// One request per cycle while req_ready is high; results are registered. The
// byte store is a two-read-port RAM; the byte at the pointer and the one after
// it are read at the edge that settles the pointer, so an ack slot never waits.
// Reset is synchronous; the byte store is not cleared.
// A two-entry output buffer keeps req_ready high while one result is stalled.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_eeprom_slave_core (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [swes_pkg::FUNC_W-1:0]       req_func,
   input  wire  [swes_pkg::DUR_W-1:0]        req_duration,
   input  wire  [swes_pkg::LA_W-1:0]         req_load_address,
   input  wire  [swes_pkg::BYTE_W-1:0]       req_load_data,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_drive_low,
   output logic [swes_pkg::ST_W-1:0]         rsp_bus_state,
   output logic [swes_pkg::PTR_W-1:0]        rsp_address_pointer,
   input  wire                               csr_write,
   input  wire  [swes_pkg::CSR_IW-1:0]       csr_index,
   input  wire  [swes_pkg::CSR_DW-1:0]       csr_wdata
);

   typedef enum logic [swes_pkg::ST_W-1:0] {
      PH_RESET = 3'd0,
      PH_CMD   = 3'd1,
      PH_ADDR  = 3'd2,
      PH_DATA  = 3'd3,
      PH_TX    = 3'd4,
      PH_IDLE  = 3'd5
   } phase_type;

   typedef struct packed {
      logic                         drive;
      logic [swes_pkg::ST_W-1:0]    st;
      logic [swes_pkg::PTR_W-1:0]   ptr;
   } result_type;

   // configuration
   logic [swes_pkg::DUR_W-1:0]  reset_low_ff;
   logic [swes_pkg::DUR_W-1:0]  one_bit_ff;
   logic [swes_pkg::DUR_W-1:0]  disc_high_ff;
   logic [swes_pkg::DEV_W-1:0]  dev_select_ff;
   logic [swes_pkg::ID_W-1:0]   mfg_id_ff;

   // bus state
   phase_type                   phase_ff, phase_in;
   logic [3:0]                  bits_ff, bits_in;
   logic [7:0]                  shift_ff, shift_in;
   logic                        zero_ff, zero_in;
   logic                        ack_ff, ack_in;
   logic                        skip_ff, skip_in;
   logic                        is_id_ff, is_id_in;
   logic [swes_pkg::PTR_W-1:0]  ptr_ff, ptr_in;
   logic [swes_pkg::BP_W-1:0]   bp_ff, bp_in;

   // output buffer
   logic                        out_valid_ff;
   result_type                  out_ff;
   logic                        skid_valid_ff;
   result_type                  skid_ff;

   logic                        accept;
   logic                        drive;
   result_type                  res;
   logic                        rx_bit;
   logic [7:0]                  rx_shift;
   logic [3:0]                  rx_count;
   logic [swes_pkg::BYTE_W-1:0] mem_a;
   logic [swes_pkg::BYTE_W-1:0] mem_b;
   logic [swes_pkg::PTR_W-1:0]  ptr_next1;
   swes_pkg::adv_type           adv_a;
   swes_pkg::adv_type           adv_b;
   logic                        ram_we;
   logic [swes_pkg::MEM_AW-1:0] ram_waddr;
   logic [swes_pkg::MEM_AW-1:0] ram_raddr_a;
   logic [swes_pkg::MEM_AW-1:0] ram_raddr_b;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   assign rx_bit    = req_duration < one_bit_ff;
   assign rx_shift  = {shift_ff[6:0], rx_bit};
   assign rx_count  = bits_ff + 4'd1;
   assign ptr_next1 = ptr_ff + swes_pkg::PTR_W'(1);

   // mem_a holds the byte at the wrapped pointer, mem_b the byte after it
   assign adv_a = swes_pkg::advance(is_id_ff, ptr_ff, bp_ff, mem_a, mfg_id_ff);
   assign adv_b = swes_pkg::advance(is_id_ff, ptr_next1, '0, mem_b, mfg_id_ff);

   always_comb begin
      phase_in = phase_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      zero_in  = zero_ff;
      ack_in   = ack_ff;
      skip_in  = skip_ff;
      is_id_in = is_id_ff;
      ptr_in   = ptr_ff;
      bp_in    = bp_ff;
      drive    = 1'b0;
      ram_we   = 1'b0;
      if (accept) begin
         case (req_func)
            swes_pkg::FUNC_ROSE: begin
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else if (req_duration > reset_low_ff) begin
                  phase_in = PH_RESET;
                  bits_in  = '0;
                  shift_in = '0;
                  zero_in  = 1'b1;
                  ptr_in   = '0;
                  bp_in    = '0;
               end else if (phase_ff == PH_TX) begin
                  if (ack_ff) begin
                     ack_in = 1'b0;
                     if (!rx_bit) begin
                        ptr_in  = adv_b.ptr;
                        bp_in   = adv_b.bp;
                        zero_in = zero_ff | adv_b.zero;
                        ack_in  = adv_b.ack;
                     end else begin
                        phase_in = PH_CMD;
                     end
                  end
               end else if (rx_count[3]) begin
                  bits_in  = '0;
                  shift_in = '0;
                  if (phase_ff == PH_CMD) begin
                     if (rx_shift[3:1] == dev_select_ff) begin
                        if (rx_shift[7:4] == swes_pkg::OPC_IDENT) begin
                           if (rx_shift[0]) begin
                              is_id_in = 1'b1;
                              bp_in    = '0;
                              ptr_in   = '0;
                              phase_in = PH_TX;
                              zero_in  = 1'b1;
                           end
                        end else if (rx_shift[7:4] == swes_pkg::OPC_MEMORY) begin
                           phase_in = rx_shift[0] ? PH_TX : PH_ADDR;
                           is_id_in = 1'b0;
                           bp_in    = '0;
                           zero_in  = 1'b1;
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end
                  end else if (phase_ff == PH_ADDR) begin
                     ptr_in   = rx_shift;
                     bp_in    = '0;
                     phase_in = PH_CMD;
                     zero_in  = 1'b1;
                  end
               end else begin
                  bits_in  = rx_count;
                  shift_in = rx_shift;
               end
            end
            swes_pkg::FUNC_FELL: begin
               if (zero_ff) begin
                  drive   = 1'b1;
                  zero_in = 1'b0;
                  skip_in = 1'b1;
               end
               if (phase_ff == PH_TX) begin
                  ptr_in  = adv_a.ptr;
                  bp_in   = adv_a.bp;
                  zero_in = adv_a.zero;
                  ack_in  = ack_ff | adv_a.ack;
               end else if (phase_ff == PH_RESET && req_duration >= disc_high_ff) begin
                  phase_in = PH_CMD;
                  bits_in  = '0;
                  shift_in = '0;
               end
            end
            swes_pkg::FUNC_TIMEOUT: begin
               if (phase_ff == PH_TX || phase_ff == PH_ADDR || phase_ff == PH_DATA) begin
                  phase_in = PH_CMD;
                  bits_in  = '0;
                  shift_in = '0;
               end
            end
            swes_pkg::FUNC_ENRESET: begin
               phase_in = PH_IDLE;
               bits_in  = '0;
               shift_in = '0;
               zero_in  = 1'b0;
               ptr_in   = '0;
               bp_in    = '0;
            end
            swes_pkg::FUNC_PRELOAD: begin
               ram_we = {1'b0, req_load_address} < (swes_pkg::LA_W+1)'(swes_pkg::MEM_BYTES);
            end
            default: begin
            end
         endcase
      end
   end

   assign res.drive = drive;
   assign res.st    = phase_in;
   assign res.ptr   = ptr_in;

   // fetch for the state that this edge settles
   assign ram_waddr   = swes_pkg::MEM_AW'(req_load_address);
   assign ram_raddr_a = swes_pkg::MEM_AW'(swes_pkg::wrap_ptr(is_id_in, ptr_in));
   assign ram_raddr_b = swes_pkg::MEM_AW'(swes_pkg::wrap_ptr(is_id_in,
                                            ptr_in + swes_pkg::PTR_W'(1)));

   swes_ram #(
      .WIDTH (swes_pkg::BYTE_W),
      .DEPTH (swes_pkg::MEM_BYTES)
   ) u_mem (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (req_load_data),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (mem_a),
      .rdata_b (mem_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff  <= swes_pkg::RESET_LOW_DEFAULT;
         one_bit_ff    <= swes_pkg::ONE_BIT_DEFAULT;
         disc_high_ff  <= swes_pkg::DISC_HIGH_DEFAULT;
         dev_select_ff <= '0;
         mfg_id_ff     <= '0;
         phase_ff      <= PH_IDLE;
         bits_ff       <= '0;
         shift_ff      <= '0;
         zero_ff       <= 1'b0;
         ack_ff        <= 1'b0;
         skip_ff       <= 1'b0;
         is_id_ff      <= 1'b0;
         ptr_ff        <= '0;
         bp_ff         <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               swes_pkg::CSR_RESET_LOW:  reset_low_ff  <= csr_wdata[swes_pkg::DUR_W-1:0];
               swes_pkg::CSR_ONE_BIT:    one_bit_ff    <= csr_wdata[swes_pkg::DUR_W-1:0];
               swes_pkg::CSR_DISC_HIGH:  disc_high_ff  <= csr_wdata[swes_pkg::DUR_W-1:0];
               swes_pkg::CSR_DEV_SELECT: dev_select_ff <= csr_wdata[swes_pkg::DEV_W-1:0];
               swes_pkg::CSR_MFG_ID:     mfg_id_ff     <= csr_wdata[swes_pkg::ID_W-1:0];
               default: begin
               end
            endcase
         end
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         zero_ff  <= zero_in;
         ack_ff   <= ack_in;
         skip_ff  <= skip_in;
         is_id_ff <= is_id_in;
         ptr_ff   <= ptr_in;
         bp_ff    <= bp_in;
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff  <= skid_valid_ff || accept;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
      if (!out_valid_ff || rsp_ready) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_drive_low       = out_ff.drive;
   assign rsp_bus_state       = out_ff.st;
   assign rsp_address_pointer = out_ff.ptr;

`ifndef SYNTHESIS
   a_drive_on_fall_only: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func != swes_pkg::FUNC_FELL) |-> !drive)
      else $error("line driven low on an event other than a falling edge");

   a_drive_sets_skip: assert property (@(posedge clock) disable iff (reset)
      (accept && drive) |=> skip_ff)
      else $error("own rising edge not marked for skipping after a drive");

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register is empty");

   a_no_data_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_DATA)
      else $error("data phase entered");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && !out_valid_ff) |=> out_valid_ff)
      else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire
